FILE: hw/rtl/btlv_pkg.sv
`default_nettype none

package btlv_pkg;

    // parse phases
    localparam logic [2:0] PH_IDENT   = 3'd0;
    localparam logic [2:0] PH_TAG     = 3'd1;
    localparam logic [2:0] PH_LEN1    = 3'd2;
    localparam logic [2:0] PH_LENN    = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_INDEFINITE = 2'd1;
    localparam logic [1:0] ERR_LEN_LONG   = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd3;

    // longest long-form length accepted, in bytes (1..8)
    localparam int MAX_LENGTH_BYTES = 8;

    localparam int TDATA_W = 144;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [1:0]  tag_class;
        logic        is_constructed;
        logic [63:0] tag_number;
        logic [63:0] content_length;
        logic [7:0]  content_byte;
        logic [1:0]  error_code;
        logic        buffer_done;
    } btlv_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ber_tlv_header_parser.sv
// Two register stages: an accepted input beat waits in the input register; its result
// then goes into the result register and is presented on m_*.
// Throughput: one byte per cycle unless stalled; the phase machine steps once per byte.
// s_tready drops only while the result register is full and m_tready is low.
// Reset (aresetn low, synchronous) empties both stage registers and returns the
// parser to expecting an identifier octet with all accumulators cleared.
`default_nettype none

module ber_tlv_header_parser
    import btlv_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // in_byte
    input  wire logic               s_tlast,   // end_of_buffer
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // tag_class[1:0], is_constructed[2],
                                               // tag_number[66:3], content_length[130:67],
                                               // content_byte[138:131], error_code[140:139],
                                               // zero pad[143:141]
    output logic [1:0]              m_tuser,   // out_kind
    output logic                    m_tlast    // buffer_done
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    btlv_result_t out_reg;

    logic         advance;
    logic         core_valid;
    btlv_result_t core_res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    btlv_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_valid_reg && advance),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    // load a result beat when the held byte moves on and the core produces a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && core_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && core_valid) begin
            out_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.out_kind;
    assign m_tlast  = out_reg.buffer_done;
    assign m_tdata  = {3'b000, out_reg.error_code, out_reg.content_byte,
                       out_reg.content_length, out_reg.tag_number,
                       out_reg.is_constructed, out_reg.tag_class};

endmodule

`default_nettype wire

FILE: hw/rtl/btlv_parse_core.sv
`default_nettype none

module btlv_parse_core
    import btlv_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    output logic              res_valid,
    output btlv_result_t      res
);

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  class_reg, class_next;
    logic        cons_reg, cons_next;
    logic [63:0] tag_reg, tag_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  lbytes_reg, lbytes_next;
    logic [63:0] left_reg, left_next;

    logic        err;
    logic        hdr_done;
    logic [63:0] left_dec;

    assign left_dec = left_reg - 64'd1;

    always_comb begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        cons_next   = cons_reg;
        tag_next    = tag_reg;
        len_next    = len_reg;
        lbytes_next = lbytes_reg;
        left_next   = left_reg;
        err         = 1'b0;
        hdr_done    = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        unique case (phase_reg)
            PH_IDENT: begin
                class_next = in_byte[7:6];
                cons_next  = in_byte[5];
                len_next   = '0;
                if (in_byte[4:0] == 5'b11111) begin
                    tag_next   = '0;
                    phase_next = PH_TAG;
                end else begin
                    tag_next   = {59'd0, in_byte[4:0]};
                    phase_next = PH_LEN1;
                end
            end
            PH_TAG: begin
                tag_next = {tag_reg[56:0], in_byte[6:0]};
                if (!in_byte[7]) begin
                    phase_next = PH_LEN1;
                end
            end
            PH_LEN1: begin
                if (!in_byte[7]) begin
                    len_next = {56'd0, in_byte};
                    hdr_done = 1'b1;
                end else if (in_byte[6:0] == 7'd0) begin
                    err            = 1'b1;
                    res_valid      = 1'b1;
                    res.out_kind   = KIND_ERROR;
                    res.error_code = ERR_INDEFINITE;
                end else if (in_byte[6:0] > 7'(MAX_LENGTH_BYTES)) begin
                    err            = 1'b1;
                    res_valid      = 1'b1;
                    res.out_kind   = KIND_ERROR;
                    res.error_code = ERR_LEN_LONG;
                end else begin
                    len_next    = '0;
                    lbytes_next = in_byte[3:0];
                    phase_next  = PH_LENN;
                end
            end
            PH_LENN: begin
                len_next    = {len_reg[55:0], in_byte};
                lbytes_next = lbytes_reg - 4'd1;
                if (lbytes_reg == 4'd1) begin
                    hdr_done = 1'b1;
                end
            end
            PH_DATA: begin
                res_valid        = 1'b1;
                res.out_kind     = KIND_BYTE;
                res.content_byte = in_byte;
                left_next        = left_dec;
                if (left_dec == 64'd0) begin
                    phase_next = PH_IDENT;
                end
            end
            default: begin
                // discard until the final byte, no result
            end
        endcase

        if (hdr_done) begin
            res_valid          = 1'b1;
            res.out_kind       = KIND_HEADER;
            res.tag_class      = class_next;
            res.is_constructed = cons_next;
            res.tag_number     = tag_next;
            res.content_length = len_next;
            left_next          = len_next;
            phase_next         = (!cons_next && len_next != 64'd0) ? PH_DATA : PH_IDENT;
        end

        if (err) begin
            phase_next = PH_DISCARD;
        end

        if (in_last) begin
            if (phase_reg != PH_IDENT && phase_reg != PH_TAG && phase_reg != PH_LEN1 &&
                phase_reg != PH_LENN && phase_reg != PH_DATA) begin
                res_valid = 1'b0;
            end else begin
                if (!err && phase_next != PH_IDENT) begin
                    res            = '0;
                    res_valid      = 1'b1;
                    res.out_kind   = KIND_ERROR;
                    res.error_code = ERR_TRUNCATED;
                end
                res.buffer_done = 1'b1;
            end
            // back to the reset state for the next buffer
            phase_next  = PH_IDENT;
            class_next  = '0;
            cons_next   = 1'b0;
            tag_next    = '0;
            len_next    = '0;
            lbytes_next = '0;
            left_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDENT;
            class_reg  <= '0;
            cons_reg   <= 1'b0;
            tag_reg    <= '0;
            len_reg    <= '0;
            lbytes_reg <= '0;
            left_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            cons_reg   <= cons_next;
            tag_reg    <= tag_next;
            len_reg    <= len_next;
            lbytes_reg <= lbytes_next;
            left_reg   <= left_next;
        end
    end

endmodule

`default_nettype wire

FILE: verif/tb_ber_tlv_header_parser.sv
`timescale 1ns / 100ps

import btlv_pkg::*;

class tlv_scoreboard;
    localparam logic [4:0] TAG_ESCAPE = 5'h1F;

    logic [2:0]   phase;
    logic [1:0]   cls;
    logic         cons;
    logic [63:0]  tag_acc;
    logic [63:0]  len_acc;
    logic [3:0]   len_left;
    logic [63:0]  remain;
    btlv_result_t expected_records[$];
    int           mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        phase    = PH_IDENT;
        cls      = '0;
        cons     = 1'b0;
        tag_acc  = '0;
        len_acc  = '0;
        len_left = '0;
        remain   = '0;
    endfunction

    function int pending();
        return expected_records.size();
    endfunction

    // Header is complete: content bytes follow only for a primitive with a nonzero length.
    function btlv_result_t header_record();
        btlv_result_t rec;
        rec = '0;
        rec.out_kind       = KIND_HEADER;
        rec.tag_class      = cls;
        rec.is_constructed = cons;
        rec.tag_number     = tag_acc;
        rec.content_length = len_acc;
        remain = len_acc;
        if (!cons && len_acc != 0) phase = PH_DATA;
        else phase = PH_IDENT;
        return rec;
    endfunction

    function btlv_result_t error_record(logic [1:0] code);
        btlv_result_t rec;
        rec = '0;
        rec.out_kind   = KIND_ERROR;
        rec.error_code = code;
        return rec;
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
        btlv_result_t rec;
        bit produced;
        bit failed;
        rec = '0;
        produced = 1'b0;
        failed = 1'b0;
        case (phase)
            PH_IDENT: begin
                cls = b[7:6];
                cons = b[5];
                len_acc = '0;
                if (b[4:0] == TAG_ESCAPE) begin
                    tag_acc = '0;
                    phase = PH_TAG;
                end else begin
                    tag_acc = {59'd0, b[4:0]};
                    phase = PH_LEN1;
                end
            end
            PH_TAG: begin
                tag_acc = {tag_acc[56:0], b[6:0]};
                if (!b[7]) phase = PH_LEN1;
            end
            PH_LEN1: begin
                if (!b[7]) begin
                    len_acc = {56'd0, b};
                    rec = header_record();
                    produced = 1'b1;
                end else if (b[6:0] == 7'd0) begin
                    rec = error_record(ERR_INDEFINITE);
                    produced = 1'b1;
                    failed = 1'b1;
                end else if (b[6:0] > MAX_LENGTH_BYTES) begin
                    rec = error_record(ERR_LEN_LONG);
                    produced = 1'b1;
                    failed = 1'b1;
                end else begin
                    len_acc = '0;
                    len_left = b[3:0];
                    phase = PH_LENN;
                end
            end
            PH_LENN: begin
                len_acc = {len_acc[55:0], b};
                len_left = len_left - 4'd1;
                if (len_left == 4'd0) begin
                    rec = header_record();
                    produced = 1'b1;
                end
            end
            PH_DATA: begin
                rec.out_kind = KIND_BYTE;
                rec.content_byte = b;
                produced = 1'b1;
                remain = remain - 64'd1;
                if (remain == 64'd0) phase = PH_IDENT;
            end
            default: begin
                // drop everything up to the final byte
                if (eob) restart();
                return;
            end
        endcase
        if (failed) phase = PH_DISCARD;
        if (eob) begin
            if (!failed && phase != PH_IDENT) begin
                rec = error_record(ERR_TRUNCATED);
                produced = 1'b1;
            end
            rec.buffer_done = 1'b1;
            restart();
        end
        if (produced) expected_records.insert(expected_records.size(), rec);
    endfunction

    task report(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_record(logic [TDATA_W-1:0] data, logic [1:0] kind, logic done);
        btlv_result_t want;
        if (expected_records.size() == 0) begin
            report($sformatf("result with nothing expected, kind %0d", kind));
            return;
        end
        want = expected_records.pop_front();
        if (kind !== want.out_kind)
            report($sformatf("out_kind got %0d want %0d", kind, want.out_kind));
        if (data[1:0] !== want.tag_class)
            report($sformatf("tag_class got %0d want %0d", data[1:0], want.tag_class));
        if (data[2] !== want.is_constructed)
            report($sformatf("is_constructed got %0d want %0d", data[2], want.is_constructed));
        if (data[66:3] !== want.tag_number)
            report($sformatf("tag_number got %h want %h", data[66:3], want.tag_number));
        if (data[130:67] !== want.content_length)
            report($sformatf("content_length got %h want %h", data[130:67],
                             want.content_length));
        if (data[138:131] !== want.content_byte)
            report($sformatf("content_byte got %h want %h", data[138:131], want.content_byte));
        if (data[140:139] !== want.error_code)
            report($sformatf("error_code got %0d want %0d", data[140:139], want.error_code));
        if (done !== want.buffer_done)
            report($sformatf("buffer_done got %0d want %0d", done, want.buffer_done));
    endtask
endclass

module tb_ber_tlv_header_parser;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 600000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b1;
    logic [TDATA_W-1:0]  m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    tlv_scoreboard sb = new();
    logic [7:0]    buf_q[$];
    int            items_sent = 0;
    bit            calm_run = 1'b0;
    int            cycle_count = 0;

    ber_tlv_header_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (calm_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // append one byte to the buffer under construction
    function automatic void add_byte(logic [7:0] b);
        buf_q.insert(buf_q.size(), b);
    endfunction

    // random element: identifier, length, then content or children
    function automatic void add_element(int depth);
        logic [7:0]  id;
        logic [63:0] lv;
        int          tag_len;
        int          len_bytes;
        int          clen;
        int          nchild;
        logic        cons;
        cons = (depth < 2) && ($urandom_range(0, 3) == 0);
        id[7:6] = 2'($urandom_range(0, 3));
        id[5] = cons;
        if ($urandom_range(0, 2) == 0) begin
            id[4:0] = 5'h1F;
            add_byte(id);
            tag_len = $urandom_range(1, 10);
            for (int i = 0; i < tag_len; i++)
                add_byte({1'(i != tag_len - 1), 7'($urandom)});
        end else begin
            id[4:0] = 5'($urandom_range(0, 30));
            add_byte(id);
        end
        if (cons) begin
            if ($urandom_range(0, 1) == 0) begin
                add_byte(8'($urandom_range(0, 127)));
            end else begin
                len_bytes = $urandom_range(1, MAX_LENGTH_BYTES);
                add_byte(8'h80 | 8'(len_bytes));
                for (int i = 0; i < len_bytes; i++) add_byte(8'($urandom));
            end
            nchild = $urandom_range(0, 3);
            for (int i = 0; i < nchild; i++) add_element(depth + 1);
        end else begin
            clen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
            lv = 64'(clen);
            if ($urandom_range(0, 9) < 7) begin
                add_byte(8'(clen));
            end else begin
                len_bytes = $urandom_range(1, MAX_LENGTH_BYTES);
                add_byte(8'h80 | 8'(len_bytes));
                for (int i = len_bytes - 1; i >= 0; i--) add_byte(lv[8*i +: 8]);
            end
            for (int i = 0; i < clen; i++) add_byte(8'($urandom));
        end
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b, last);
        items_sent++;
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buf_q.size(); i++)
            send_beat(buf_q[i], i == buf_q.size() - 1);
    endtask

    // lower valid and hold off until the result side has drained
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        int kind;
        int nelem;
        int keep;
        int nfill;
        int buf_idx;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short form, one content byte
        buf_q = '{8'h02, 8'h01, 8'hFF};
        send_buffer();
        // private constructed, two-byte tag, zero length
        buf_q = '{8'hFF, 8'h81, 8'h00, 8'h00};
        send_buffer();
        // zero-length primitive
        buf_q = '{8'h05, 8'h00};
        send_buffer();
        // long-form length
        buf_q = '{8'h04, 8'h82, 8'h00, 8'h01, 8'hAB};
        send_buffer();
        // indefinite length, then the tail is dropped
        buf_q = '{8'h30, 8'h80, 8'h11, 8'h22};
        send_buffer();
        // length count over the limit on the final byte
        buf_q = '{8'h04, 8'h89};
        send_buffer();
        // content cut short by the final byte
        buf_q = '{8'h04, 8'h05, 8'h01};
        send_buffer();
        // final byte leaves the header unfinished
        buf_q = '{8'h1F};
        send_buffer();
        drain_results();

        buf_idx = 0;
        while (items_sent < RANDOM_ITEMS + 24) begin
            calm_run = ($urandom_range(0, 7) == 0);
            buf_q.delete();
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                nelem = $urandom_range(1, 4);
                for (int i = 0; i < nelem; i++) add_element(0);
            end else if (kind < 85) begin
                nelem = $urandom_range(1, 3);
                for (int i = 0; i < nelem; i++) add_element(0);
                keep = $urandom_range(1, buf_q.size());
                while (buf_q.size() > keep) void'(buf_q.pop_back());
            end else if (kind < 95) begin
                nelem = $urandom_range(0, 2);
                for (int i = 0; i < nelem; i++) add_element(0);
                add_byte({2'($urandom), 1'($urandom), 5'($urandom_range(0, 30))});
                if ($urandom_range(0, 1) == 0) add_byte(8'h80);
                else add_byte(8'($urandom_range(8'h89, 8'hFF)));
                nfill = $urandom_range(0, 6);
                for (int i = 0; i < nfill; i++) add_byte(8'($urandom));
            end else begin
                nfill = $urandom_range(1, 16);
                for (int i = 0; i < nfill; i++) add_byte(8'($urandom));
            end
            send_buffer();
            buf_idx++;
            if (buf_idx == 3 || $urandom_range(0, 39) == 0) drain_results();
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ber_tlv_header_parser regression: pass");
        end else begin
            $display("ber_tlv_header_parser regression: fail");
        end
        $finish;
    end

    // result side backpressure: runs of ready, each sometimes followed by a stall
    initial begin
        int stall;
        forever begin
            m_tready <= 1'b1;
            repeat (1 + pick_gap()) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_record(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("ber_tlv_header_parser regression: fail");
        $finish;
    end
endmodule
